### design/peb_pkg.sv
// shared types, codes and helpers of the plane equation builder
package peb_pkg;

  localparam logic [1:0] ACT_POINTS = 2'd0;
  localparam logic [1:0] ACT_DIRS   = 2'd1;
  localparam logic [1:0] ACT_NORMAL = 2'd2;

  localparam logic [2:0] CLS_EXACT_X = 3'd0;
  localparam logic [2:0] CLS_EXACT_Y = 3'd1;
  localparam logic [2:0] CLS_EXACT_Z = 3'd2;
  localparam logic [2:0] CLS_DOM_X   = 3'd3;
  localparam logic [2:0] CLS_DOM_Y   = 3'd4;
  localparam logic [2:0] CLS_DOM_Z   = 3'd5;

  localparam logic signed [31:0] Q30_ONE     = 32'sh4000_0000;
  localparam logic signed [31:0] Q30_NEG_ONE = -32'sh4000_0000;

  localparam int SQ_STEPS = 32;
  localparam int DV_STEPS = 31;

  typedef struct packed {
    logic            degen;
    logic [2:0]      neg;
    logic [2:0][30:0] mag;
    logic [2:0][31:0] org;
  } peb_carry_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
    peb_carry_t  c;
  } peb_sq_t;

  typedef struct packed {
    logic [31:0]      rt;
    logic [2:0][31:0] rem;
    logic [2:0][30:0] nlo;
    logic [2:0][30:0] quo;
    peb_carry_t       c;
  } peb_dv_t;

  function automatic logic [5:0] lead_one(input logic [61:0] x);
    logic [5:0] h;
    h = '0;
    for (int i = 0; i < 62; i++) begin
      if (x[i]) begin
        h = 6'(i);
      end
    end
    return h;
  endfunction

endpackage

### design/peb_in_if.sv
// input and result channel interfaces of the plane equation builder
interface peb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [31:0] v0_x;
  logic signed [31:0] v0_y;
  logic signed [31:0] v0_z;
  logic signed [31:0] v1_x;
  logic signed [31:0] v1_y;
  logic signed [31:0] v1_z;
  logic signed [31:0] v2_x;
  logic signed [31:0] v2_y;
  logic signed [31:0] v2_z;

  modport source (output valid, action, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                  v2_x, v2_y, v2_z, input ready);
  modport sink (input valid, action, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                v2_x, v2_y, v2_z, output ready);
endinterface

interface peb_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] normal_x;
  logic signed [31:0] normal_y;
  logic signed [31:0] normal_z;
  logic signed [31:0] plane_offset;
  logic [2:0]  plane_class;
  logic        degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, plane_offset,
                  plane_class, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, plane_offset,
                plane_class, degenerate, output ready);
endinterface

### design/plane_equation_builder_core.sv
// plane equation builder: one unit plane normal, offset and class per word
// A fully pipelined datapath that accepts one word per clock and returns one
// result word per input word, in order. Nine front stages form the cross
// product and bring the normal to a fixed range, a sum stage and 32 stages
// take the square root of its squared length one result bit per stage, a
// setup stage and 31 stages divide the three components by that length one
// quotient bit per stage, three back stages form the signed normal, the
// offset products and their sum, and the output register holds the normal,
// the offset and the class. A stall at the result side holds the whole
// pipeline; bubbles in flight keep moving while the output register is empty.
module plane_equation_builder_core (
  input logic         clk,
  input logic         rst_n,
  peb_in_if.sink      in_if,
  peb_out_if.source   out_if
);
  import peb_pkg::*;

  logic en;
  logic signed [31:0] iv0 [3];
  logic signed [31:0] iv1 [3];
  logic signed [31:0] iv2 [3];

  assign en = !out_if.valid || out_if.ready;
  assign in_if.ready = en;

  assign iv0[0] = in_if.v0_x;
  assign iv0[1] = in_if.v0_y;
  assign iv0[2] = in_if.v0_z;
  assign iv1[0] = in_if.v1_x;
  assign iv1[1] = in_if.v1_y;
  assign iv1[2] = in_if.v1_z;
  assign iv2[0] = in_if.v2_x;
  assign iv2[1] = in_if.v2_y;
  assign iv2[2] = in_if.v2_z;

  logic fv_r [1:9];

  // stage 1: cross operands
  logic               cross1_r, cross1_nxt;
  logic signed [32:0] u1_r [3], u1_nxt [3];
  logic signed [32:0] w1_r [3], w1_nxt [3];
  logic [31:0]        o1_r [3], o1_nxt [3];
  logic [31:0]        d1_r [3], d1_nxt [3];

  always_comb begin
    cross1_nxt = (in_if.action == ACT_POINTS) || (in_if.action == ACT_DIRS);
    for (int j = 0; j < 3; j++) begin
      d1_nxt[j] = iv1[j];
      case (in_if.action)
        ACT_POINTS: begin
          u1_nxt[j] = {iv1[j][31], iv1[j]} - {iv0[j][31], iv0[j]};
          w1_nxt[j] = {iv1[j][31], iv1[j]} - {iv2[j][31], iv2[j]};
          o1_nxt[j] = iv0[j];
        end
        ACT_DIRS: begin
          u1_nxt[j] = {iv0[j][31], iv0[j]};
          w1_nxt[j] = {iv1[j][31], iv1[j]};
          o1_nxt[j] = iv2[j];
        end
        default: begin
          u1_nxt[j] = '0;
          w1_nxt[j] = '0;
          o1_nxt[j] = iv0[j];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cross1_r <= cross1_nxt;
      u1_r     <= u1_nxt;
      w1_r     <= w1_nxt;
      o1_r     <= o1_nxt;
      d1_r     <= d1_nxt;
    end
  end

  // stage 2: magnitudes and common prescale
  logic        cross2_r;
  logic [32:0] um2_r [3], um2_nxt [3];
  logic [32:0] wm2_r [3], wm2_nxt [3];
  logic [2:0]  un2_r, wn2_r;
  logic [1:0]  k2_r, k2_nxt;
  logic [31:0] o2_r [3];
  logic [31:0] d2_r [3];
  logic [32:0] or2;

  always_comb begin
    or2 = '0;
    for (int j = 0; j < 3; j++) begin
      um2_nxt[j] = u1_r[j][32] ? 33'(-u1_r[j]) : 33'(u1_r[j]);
      wm2_nxt[j] = w1_r[j][32] ? 33'(-w1_r[j]) : 33'(w1_r[j]);
      or2 = or2 | um2_nxt[j] | wm2_nxt[j];
    end
    if (or2[32]) begin
      k2_nxt = 2'd3;
    end else if (or2[31]) begin
      k2_nxt = 2'd2;
    end else if (or2[30]) begin
      k2_nxt = 2'd1;
    end else begin
      k2_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cross2_r <= cross1_r;
      um2_r    <= um2_nxt;
      wm2_r    <= wm2_nxt;
      k2_r     <= k2_nxt;
      o2_r     <= o1_r;
      d2_r     <= d1_r;
      for (int j = 0; j < 3; j++) begin
        un2_r[j] <= u1_r[j][32];
        wn2_r[j] <= w1_r[j][32];
      end
    end
  end

  // stage 3: shifted signed operands
  logic               cross3_r;
  logic signed [30:0] u3_r [3], u3_nxt [3];
  logic signed [30:0] w3_r [3], w3_nxt [3];
  logic [31:0]        o3_r [3];
  logic [31:0]        d3_r [3];
  logic [32:0]        ush3 [3], wsh3 [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ush3[j] = um2_r[j] >> k2_r;
      wsh3[j] = wm2_r[j] >> k2_r;
      u3_nxt[j] = un2_r[j] ? -$signed({1'b0, ush3[j][29:0]})
                           : $signed({1'b0, ush3[j][29:0]});
      w3_nxt[j] = wn2_r[j] ? -$signed({1'b0, wsh3[j][29:0]})
                           : $signed({1'b0, wsh3[j][29:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cross3_r <= cross2_r;
      u3_r     <= u3_nxt;
      w3_r     <= w3_nxt;
      o3_r     <= o2_r;
      d3_r     <= d2_r;
    end
  end

  // stage 4: six products
  logic               cross4_r;
  logic signed [61:0] pa4_r [3], pb4_r [3];
  logic [31:0]        o4_r [3];
  logic [31:0]        d4_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      cross4_r <= cross3_r;
      o4_r     <= o3_r;
      d4_r     <= d3_r;
      pa4_r[0] <= u3_r[1] * w3_r[2];
      pb4_r[0] <= u3_r[2] * w3_r[1];
      pa4_r[1] <= u3_r[2] * w3_r[0];
      pb4_r[1] <= u3_r[0] * w3_r[2];
      pa4_r[2] <= u3_r[0] * w3_r[1];
      pb4_r[2] <= u3_r[1] * w3_r[0];
    end
  end

  // stage 5: raw normal
  logic signed [62:0] n5_r [3], n5_nxt [3];
  logic [31:0]        o5_r [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (cross4_r) begin
        n5_nxt[j] = 63'(pa4_r[j]) - 63'(pb4_r[j]);
      end else begin
        n5_nxt[j] = 63'($signed(d4_r[j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n5_r <= n5_nxt;
      o5_r <= o4_r;
    end
  end

  // stage 6: normal magnitudes
  logic [61:0] nm6_r [3], nm6_nxt [3];
  logic [61:0] or6_r, or6_nxt;
  logic [2:0]  nn6_r;
  logic [31:0] o6_r [3];

  always_comb begin
    or6_nxt = '0;
    for (int j = 0; j < 3; j++) begin
      nm6_nxt[j] = n5_r[j][62] ? 62'(-n5_r[j]) : 62'(n5_r[j]);
      or6_nxt = or6_nxt | nm6_nxt[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm6_r <= nm6_nxt;
      or6_r <= or6_nxt;
      o6_r  <= o5_r;
      for (int j = 0; j < 3; j++) begin
        nn6_r[j] <= n5_r[j][62];
      end
    end
  end

  // stage 7: leading one of the largest magnitude
  logic [61:0] nm7_r [3];
  logic [5:0]  h7_r;
  logic [2:0]  nn7_r;
  logic        dg7_r;
  logic [31:0] o7_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      nm7_r <= nm6_r;
      h7_r  <= lead_one(or6_r);
      nn7_r <= nn6_r;
      dg7_r <= (or6_r == '0);
      o7_r  <= o6_r;
    end
  end

  // stage 8: normal brought to [2^30, 2^31)
  peb_carry_t c8_r, c8_nxt;
  logic [61:0] sh8 [3];

  always_comb begin
    c8_nxt.degen = dg7_r;
    c8_nxt.neg   = nn7_r;
    for (int j = 0; j < 3; j++) begin
      if (h7_r >= 6'd30) begin
        sh8[j] = nm7_r[j] >> (h7_r - 6'd30);
      end else begin
        sh8[j] = nm7_r[j] << (6'd30 - h7_r);
      end
      c8_nxt.mag[j] = sh8[j][30:0];
      c8_nxt.org[j] = o7_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c8_r <= c8_nxt;
    end
  end

  // stage 9: squares
  peb_carry_t  c9_r;
  logic [61:0] sq9_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c9_r <= c8_r;
      for (int j = 0; j < 3; j++) begin
        sq9_r[j] <= 62'(c8_r.mag[j]) * 62'(c8_r.mag[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 9; k++) begin
        fv_r[k] <= 1'b0;
      end
    end else if (en) begin
      fv_r[1] <= in_if.valid;
      for (int k = 2; k <= 9; k++) begin
        fv_r[k] <= fv_r[k-1];
      end
    end
  end

  // square root, one result bit per stage
  peb_sq_t sq_r   [SQ_STEPS+1];
  peb_sq_t sq_nxt [SQ_STEPS];
  logic    sqv_r  [SQ_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0].rem  <= 64'(sq9_r[0]) + 64'(sq9_r[1]) + 64'(sq9_r[2]);
      sq_r[0].root <= '0;
      sq_r[0].c    <= c9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r[0] <= 1'b0;
    end else if (en) begin
      sqv_r[0] <= fv_r[9];
    end
  end

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    localparam int SH = 2 * (SQ_STEPS - 1 - g);
    logic [63:0] bitv;
    logic [63:0] trial;

    always_comb begin
      bitv  = 64'd1 << SH;
      trial = sq_r[g].root + bitv;
      sq_nxt[g].c = sq_r[g].c;
      if (sq_r[g].rem >= trial) begin
        sq_nxt[g].rem  = sq_r[g].rem - trial;
        sq_nxt[g].root = (sq_r[g].root >> 1) + bitv;
      end else begin
        sq_nxt[g].rem  = sq_r[g].rem;
        sq_nxt[g].root = sq_r[g].root >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[g+1] <= sq_nxt[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqv_r[g+1] <= 1'b0;
      end else if (en) begin
        sqv_r[g+1] <= sqv_r[g];
      end
    end
  end

  // rounded division of each component by the length
  peb_dv_t dv_r   [DV_STEPS+1];
  peb_dv_t dv_nxt [DV_STEPS];
  logic    dvv_r  [DV_STEPS+1];
  peb_dv_t dv0_nxt;
  logic [61:0] num0 [3];

  always_comb begin
    dv0_nxt.rt = sq_r[SQ_STEPS].root[31:0];
    dv0_nxt.c  = sq_r[SQ_STEPS].c;
    for (int j = 0; j < 3; j++) begin
      num0[j] = {1'b0, sq_r[SQ_STEPS].c.mag[j], 30'd0}
                + 62'(sq_r[SQ_STEPS].root[32:1]);
      dv0_nxt.rem[j] = {1'b0, num0[j][61:31]};
      dv0_nxt.nlo[j] = num0[j][30:0];
      dv0_nxt.quo[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvv_r[0] <= 1'b0;
    end else if (en) begin
      dvv_r[0] <= sqv_r[SQ_STEPS];
    end
  end

  for (genvar g = 0; g < DV_STEPS; g++) begin : g_div
    localparam int BI = DV_STEPS - 1 - g;
    logic [32:0] t [3];

    always_comb begin
      dv_nxt[g] = dv_r[g];
      for (int j = 0; j < 3; j++) begin
        t[j] = {dv_r[g].rem[j], dv_r[g].nlo[j][BI]};
        if (t[j] >= {1'b0, dv_r[g].rt}) begin
          dv_nxt[g].rem[j] = 32'(t[j] - {1'b0, dv_r[g].rt});
          dv_nxt[g].quo[j][BI] = 1'b1;
        end else begin
          dv_nxt[g].rem[j] = t[j][31:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[g+1] <= dv_nxt[g];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvv_r[g+1] <= 1'b0;
      end else if (en) begin
        dvv_r[g+1] <= dvv_r[g];
      end
    end
  end

  // back end: signed normal, offset products, sum, output register
  logic               bv_r [3];
  logic signed [31:0] qa_r [3], qa_nxt [3];
  logic signed [31:0] qb_r [3];
  logic signed [31:0] qc_r [3];
  logic [31:0]        oa_r [3];
  logic signed [63:0] pr_r [3];
  logic signed [65:0] ps_r;
  logic               dga_r, dgb_r, dgc_r;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dv_r[DV_STEPS].c.degen) begin
        qa_nxt[j] = '0;
      end else if (dv_r[DV_STEPS].c.neg[j]) begin
        qa_nxt[j] = -$signed({1'b0, dv_r[DV_STEPS].quo[j]});
      end else begin
        qa_nxt[j] = $signed({1'b0, dv_r[DV_STEPS].quo[j]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa_r  <= qa_nxt;
      dga_r <= dv_r[DV_STEPS].c.degen;
      for (int j = 0; j < 3; j++) begin
        oa_r[j] <= dv_r[DV_STEPS].c.org[j];
      end
      qb_r  <= qa_r;
      dgb_r <= dga_r;
      for (int j = 0; j < 3; j++) begin
        pr_r[j] <= qa_r[j] * $signed(oa_r[j]);
      end
      qc_r  <= qb_r;
      dgc_r <= dgb_r;
      ps_r  <= 66'(pr_r[0]) + 66'(pr_r[1]) + 66'(pr_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        bv_r[k] <= 1'b0;
      end
    end else if (en) begin
      bv_r[0] <= dvv_r[DV_STEPS];
      bv_r[1] <= bv_r[0];
      bv_r[2] <= bv_r[1];
    end
  end

  logic [65:0]        pmag;
  logic [35:0]        pm;
  logic signed [31:0] off_nxt;
  logic [2:0]         cls_nxt;
  logic [30:0]        ax, ay, az;

  always_comb begin
    pmag = ps_r[65] ? 66'(-ps_r) : 66'(ps_r);
    pm   = 36'((pmag + 66'(1 << 29)) >> 30);
    if (ps_r[65]) begin
      off_nxt = (pm > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(pm[31:0]);
    end else begin
      off_nxt = (pm > 36'h0_8000_0000) ? 32'sh8000_0000 : $signed(32'(-pm));
    end
    ax = qc_r[0][31] ? 31'(-qc_r[0]) : qc_r[0][30:0];
    ay = qc_r[1][31] ? 31'(-qc_r[1]) : qc_r[1][30:0];
    az = qc_r[2][31] ? 31'(-qc_r[2]) : qc_r[2][30:0];
    if (qc_r[0] == Q30_ONE || qc_r[0] == Q30_NEG_ONE) begin
      cls_nxt = CLS_EXACT_X;
    end else if (qc_r[1] == Q30_ONE || qc_r[1] == Q30_NEG_ONE) begin
      cls_nxt = CLS_EXACT_Y;
    end else if (qc_r[2] == Q30_ONE || qc_r[2] == Q30_NEG_ONE) begin
      cls_nxt = CLS_EXACT_Z;
    end else if (ax >= ay && ax >= az) begin
      cls_nxt = CLS_DOM_X;
    end else if (ay >= ax && ay >= az) begin
      cls_nxt = CLS_DOM_Y;
    end else begin
      cls_nxt = CLS_DOM_Z;
    end
  end

  logic               vo_r;
  logic signed [31:0] nx_r, ny_r, nz_r, off_r;
  logic [2:0]         cls_r;
  logic               dg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= bv_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r  <= qc_r[0];
      ny_r  <= qc_r[1];
      nz_r  <= qc_r[2];
      off_r <= off_nxt;
      cls_r <= cls_nxt;
      dg_r  <= dgc_r;
    end
  end

  assign out_if.valid        = vo_r;
  assign out_if.normal_x     = nx_r;
  assign out_if.normal_y     = ny_r;
  assign out_if.normal_z     = nz_r;
  assign out_if.plane_offset = off_r;
  assign out_if.plane_class  = cls_r;
  assign out_if.degenerate   = dg_r;

endmodule

### design/peb_checker.sv
// port-level checks of the plane equation builder and their binding
module peb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] normal_x,
  input logic signed [31:0] normal_y,
  input logic signed [31:0] normal_z,
  input logic signed [31:0] plane_offset,
  input logic [2:0]         plane_class,
  input logic               degenerate
);
  import peb_pkg::*;

  // result valid, normal_x and offset held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(plane_offset))
    else $error("result word changed under stall");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // degenerate words are all zero with dominant x class
  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0
      && plane_offset == 0 && plane_class == CLS_DOM_X)
    else $error("degenerate word not zeroed");

  // unit normal components stay within one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> normal_x >= Q30_NEG_ONE && normal_x <= Q30_ONE
      && normal_y >= Q30_NEG_ONE && normal_y <= Q30_ONE
      && normal_z >= Q30_NEG_ONE && normal_z <= Q30_ONE)
    else $error("normal component out of range");

endmodule

bind plane_equation_builder_core peb_checker u_peb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .normal_x     (out_if.normal_x),
  .normal_y     (out_if.normal_y),
  .normal_z     (out_if.normal_z),
  .plane_offset (out_if.plane_offset),
  .plane_class  (out_if.plane_class),
  .degenerate   (out_if.degenerate)
);
